@@ src/mbe_pkg.sv @@
// shared types, register codes and fixed-point helpers for the escape-time block
`default_nettype none

package mbe_pkg;

    localparam int ITER_LIMIT_DEF = 256;

    localparam int OFS_W  = 48;
    localparam int SCL_W  = 48;
    localparam int ITR_W  = 9;
    localparam int PIX_W  = 12;
    localparam int WORD_W = 64;
    localparam int PROD_W = 128;
    localparam int ADDR_W = 6;

    // register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_X_OFFSET  = 3'd0;
    localparam logic [2:0] REG_Y_OFFSET  = 3'd1;
    localparam logic [2:0] REG_X_SCALE   = 3'd2;
    localparam logic [2:0] REG_Y_SCALE   = 3'd3;
    localparam logic [2:0] REG_MAX_ITERS = 3'd4;

    localparam logic [SCL_W-1:0] SCALE_RST = 48'h0100_0000_0000;
    localparam logic [ITR_W-1:0] ITERS_RST = 9'd256;

    // right-shift selections applied to a full product
    localparam logic [1:0] SH_MAP   = 2'd0;  // Q33.64 to Q6.58
    localparam logic [1:0] SH_SQ    = 2'd1;  // Q12.116 to Q6.58
    localparam logic [1:0] SH_CROSS = 2'd2;  // doubled cross term
    localparam logic [1:0] SH_MAG   = 2'd3;  // Q12.116 to Q8.56

    localparam logic [WORD_W-1:0] FOUR_Q856 = 64'h0400_0000_0000_0000;
    localparam logic [WORD_W-1:0] SMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] SMIN      = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [OFS_W-1:0] x_offset;
        logic [OFS_W-1:0] y_offset;
        logic [SCL_W-1:0] x_scale;
        logic [SCL_W-1:0] y_scale;
        logic [ITR_W-1:0] max_iters;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic logic [WORD_W-1:0] abs64(input logic [WORD_W-1:0] a);
        abs64 = a[WORD_W-1] ? (~a + 64'd1) : a;
    endfunction

    // shift a product right and clamp to 64 unsigned bits
    function automatic logic [WORD_W-1:0] usat_shr(input logic [PROD_W-1:0] p,
                                                   input logic [1:0] sel);
        logic [WORD_W-1:0] v;
        logic              ovf;
        v   = '0;
        ovf = 1'b0;
        unique case (sel)
            SH_MAP:   begin v = p[69:6];   ovf = |p[127:70];  end
            SH_SQ:    begin v = p[121:58]; ovf = |p[127:122]; end
            SH_CROSS: begin v = p[120:57]; ovf = |p[127:121]; end
            SH_MAG:   begin v = p[123:60]; ovf = |p[127:124]; end
        endcase
        usat_shr = ovf ? '1 : v;
    endfunction

    // apply sign to a magnitude, clamping to the signed range
    function automatic logic [WORD_W-1:0] to_signed_sat(input logic [WORD_W-1:0] m,
                                                        input logic neg);
        if (neg)
            to_signed_sat = m[WORD_W-1] ? SMIN : (~m + 64'd1);
        else
            to_signed_sat = m[WORD_W-1] ? SMAX : m;
    endfunction

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            sat_add = s[WORD_W] ? SMIN : SMAX;
        else
            sat_add = s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] usat_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        usat_add = s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/mbe_mul.sv @@
// shared 64x64 unsigned multiplier built from four passes of one 32x32 multiplier
`default_nettype none

module mbe_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [mbe_pkg::WORD_W-1:0]    a,
    input  wire logic [mbe_pkg::WORD_W-1:0]    b,
    output mbe_pkg::mul_stat_t                 stat,
    output logic      [mbe_pkg::PROD_W-1:0]    prod
);

    localparam int HW = mbe_pkg::WORD_W / 2;

    logic [mbe_pkg::WORD_W-1:0] a_reg, a_next;
    logic [mbe_pkg::WORD_W-1:0] b_reg, b_next;
    logic [1:0]                 step_reg, step_next;
    logic                       run_reg, run_next;
    logic [mbe_pkg::WORD_W-1:0] pp_reg, pp_next;
    logic [1:0]                 pp_sh_reg, pp_sh_next;
    logic                       pp_vld_reg, pp_vld_next;
    logic                       pp_last_reg, pp_last_next;
    logic [mbe_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic                       done_reg, done_next;

    logic [HW-1:0]              a_half;
    logic [HW-1:0]              b_half;
    logic [mbe_pkg::PROD_W-1:0] pp_ext;

    assign a_half = step_reg[1] ? a_reg[mbe_pkg::WORD_W-1:HW] : a_reg[HW-1:0];
    assign b_half = step_reg[0] ? b_reg[mbe_pkg::WORD_W-1:HW] : b_reg[HW-1:0];

    always_comb
    begin
        pp_ext = '0;
        unique case (pp_sh_reg)
            2'd0:    pp_ext = {64'd0, pp_reg};
            2'd1:    pp_ext = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_ext = {pp_reg, 64'd0};
            default: pp_ext = '0;
        endcase
    end

    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        step_next    = step_reg;
        run_next     = run_reg;
        pp_next      = pp_reg;
        pp_sh_next   = pp_sh_reg;
        pp_vld_next  = 1'b0;
        pp_last_next = 1'b0;
        acc_next     = acc_reg;
        done_next    = 1'b0;

        if (pp_vld_reg)
        begin
            acc_next  = acc_reg + pp_ext;
            done_next = pp_last_reg;
        end

        if (start)
        begin
            a_next    = a;
            b_next    = b;
            step_next = 2'd0;
            run_next  = 1'b1;
            acc_next  = '0;
        end
        else if (run_reg)
        begin
            pp_next      = a_half * b_half;
            pp_sh_next   = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            pp_vld_next  = 1'b1;
            pp_last_next = (step_reg == 2'd3);
            step_next    = step_reg + 2'd1;
            run_next     = (step_reg != 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            run_reg     <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            run_reg     <= run_next;
            pp_vld_reg  <= pp_vld_next;
            pp_last_reg <= pp_last_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        acc_reg   <= acc_next;
    end

    assign stat.busy = run_reg | pp_vld_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

`default_nettype wire

@@ src/mbe_regs.sv @@
// configuration register file behind the apb port
`default_nettype none

module mbe_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mbe_pkg::WORD_W-1:0]    pwdata,
    output logic      [mbe_pkg::WORD_W-1:0]    prdata,
    output logic                               pready,
    output mbe_pkg::cfg_t                      cfg
);

    mbe_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                mbe_pkg::REG_X_OFFSET:  cfg_next.x_offset  = pwdata[mbe_pkg::OFS_W-1:0];
                mbe_pkg::REG_Y_OFFSET:  cfg_next.y_offset  = pwdata[mbe_pkg::OFS_W-1:0];
                mbe_pkg::REG_X_SCALE:   cfg_next.x_scale   = pwdata[mbe_pkg::SCL_W-1:0];
                mbe_pkg::REG_Y_SCALE:   cfg_next.y_scale   = pwdata[mbe_pkg::SCL_W-1:0];
                mbe_pkg::REG_MAX_ITERS: cfg_next.max_iters = pwdata[mbe_pkg::ITR_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            mbe_pkg::REG_X_OFFSET:  prdata = {{16{cfg_reg.x_offset[47]}}, cfg_reg.x_offset};
            mbe_pkg::REG_Y_OFFSET:  prdata = {{16{cfg_reg.y_offset[47]}}, cfg_reg.y_offset};
            mbe_pkg::REG_X_SCALE:   prdata = {16'd0, cfg_reg.x_scale};
            mbe_pkg::REG_Y_SCALE:   prdata = {16'd0, cfg_reg.y_scale};
            mbe_pkg::REG_MAX_ITERS: prdata = {55'd0, cfg_reg.max_iters};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset  <= '0;
            cfg_reg.y_offset  <= '0;
            cfg_reg.x_scale   <= mbe_pkg::SCALE_RST;
            cfg_reg.y_scale   <= mbe_pkg::SCALE_RST;
            cfg_reg.max_iters <= mbe_pkg::ITERS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/mbe_core.sv @@
// sequencer that maps the pixel and runs the escape loop on the shared multiplier
`default_nettype none

module mbe_core #(
    parameter int ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mbe_pkg::cfg_t                 cfg,
    input  wire logic                          start,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_x,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_y,
    output logic                               busy,
    output logic                               done,
    output logic      [mbe_pkg::ITR_W-1:0]     iter_count,
    output logic                               in_set,
    output logic      [mbe_pkg::WORD_W-1:0]    mag_sq
);

    localparam int LIM_W = $clog2(ITER_LIMIT + 1);
    localparam int CNT_W = (LIM_W > mbe_pkg::ITR_W) ? LIM_W : mbe_pkg::ITR_W;
    localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(ITER_LIMIT);
    localparam int PW = mbe_pkg::OFS_W + 1;
    localparam int WW = mbe_pkg::WORD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MX    = 3'd1;
    localparam logic [2:0] S_MY    = 3'd2;
    localparam logic [2:0] S_SQR   = 3'd3;
    localparam logic [2:0] S_SQI   = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_CROSS = 3'd6;
    localparam logic [2:0] S_UPD   = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic                        issue_reg, issue_next;
    logic [PW-1:0]               px_reg, px_next;
    logic [PW-1:0]               py_reg, py_next;
    logic [CNT_W-1:0]            limit_reg, limit_next;
    logic [CNT_W-1:0]            it_reg, it_next;
    logic [WW-1:0]               cr_reg, cr_next;
    logic [WW-1:0]               ci_reg, ci_next;
    logic [WW-1:0]               zr_reg, zr_next;
    logic [WW-1:0]               zi_reg, zi_next;
    logic [WW-1:0]               rsq_reg, rsq_next;
    logic [WW-1:0]               isq_reg, isq_next;
    logic [WW-1:0]               magr_reg, magr_next;
    logic [WW-1:0]               mag_reg, mag_next;
    logic [WW-1:0]               dr_reg, dr_next;
    logic [WW-1:0]               cross_reg, cross_next;
    logic                        done_reg, done_next;
    logic [mbe_pkg::ITR_W-1:0]   iter_count_reg, iter_count_next;
    logic                        in_set_reg, in_set_next;
    logic [WW-1:0]               mag_sq_reg, mag_sq_next;

    logic [CNT_W-1:0]            iters_ext;
    logic [WW-1:0]               abs_zr;
    logic [WW-1:0]               abs_zi;
    logic [PW-1:0]               abs_px;
    logic [PW-1:0]               abs_py;
    logic [WW-1:0]               mul_a;
    logic [WW-1:0]               mul_b;
    logic [mbe_pkg::PROD_W-1:0]  prod;
    mbe_pkg::mul_stat_t          mstat;

    assign iters_ext = CNT_W'(cfg.max_iters);
    assign abs_zr    = mbe_pkg::abs64(zr_reg);
    assign abs_zi    = mbe_pkg::abs64(zi_reg);
    assign abs_px    = px_reg[PW-1] ? (~px_reg + PW'(1)) : px_reg;
    assign abs_py    = py_reg[PW-1] ? (~py_reg + PW'(1)) : py_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MX:
            begin
                mul_a = WW'(abs_px);
                mul_b = WW'(cfg.x_scale);
            end
            S_MY:
            begin
                mul_a = WW'(abs_py);
                mul_b = WW'(cfg.y_scale);
            end
            S_SQR:
            begin
                mul_a = abs_zr;
                mul_b = abs_zr;
            end
            S_SQI:
            begin
                mul_a = abs_zi;
                mul_b = abs_zi;
            end
            S_CROSS:
            begin
                mul_a = abs_zr;
                mul_b = abs_zi;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mbe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (issue_reg),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mstat),
        .prod  (prod)
    );

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = 1'b0;
        px_next         = px_reg;
        py_next         = py_reg;
        limit_next      = limit_reg;
        it_next         = it_reg;
        cr_next         = cr_reg;
        ci_next         = ci_reg;
        zr_next         = zr_reg;
        zi_next         = zi_reg;
        rsq_next        = rsq_reg;
        isq_next        = isq_reg;
        magr_next       = magr_reg;
        mag_next        = mag_reg;
        dr_next         = dr_reg;
        cross_next      = cross_reg;
        done_next       = 1'b0;
        iter_count_next = iter_count_reg;
        in_set_next     = in_set_reg;
        mag_sq_next     = mag_sq_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = {21'd0, pixel_x, 16'd0} + {cfg.x_offset[47], cfg.x_offset};
                    py_next    = {21'd0, pixel_y, 16'd0} + {cfg.y_offset[47], cfg.y_offset};
                    limit_next = (iters_ext > LIMIT_C) ? LIMIT_C : iters_ext;
                    it_next    = '0;
                    state_next = S_MX;
                    issue_next = 1'b1;
                end
            end
            S_MX:
            begin
                if (mstat.done)
                begin
                    cr_next = mbe_pkg::to_signed_sat(
                        mbe_pkg::usat_shr(prod, mbe_pkg::SH_MAP), px_reg[PW-1]);
                    state_next = S_MY;
                    issue_next = 1'b1;
                end
            end
            S_MY:
            begin
                if (mstat.done)
                begin
                    ci_next = mbe_pkg::to_signed_sat(
                        mbe_pkg::usat_shr(prod, mbe_pkg::SH_MAP), py_reg[PW-1]);
                    zr_next    = '0;
                    zi_next    = '0;
                    it_next    = '0;
                    state_next = S_SQR;
                    issue_next = 1'b1;
                end
            end
            S_SQR:
            begin
                // one square serves both the next step and the magnitude
                if (mstat.done)
                begin
                    rsq_next = mbe_pkg::to_signed_sat(
                        mbe_pkg::usat_shr(prod, mbe_pkg::SH_SQ), 1'b0);
                    magr_next  = mbe_pkg::usat_shr(prod, mbe_pkg::SH_MAG);
                    state_next = S_SQI;
                    issue_next = 1'b1;
                end
            end
            S_SQI:
            begin
                if (mstat.done)
                begin
                    isq_next = mbe_pkg::to_signed_sat(
                        mbe_pkg::usat_shr(prod, mbe_pkg::SH_SQ), 1'b0);
                    mag_next = mbe_pkg::usat_add(magr_reg,
                        mbe_pkg::usat_shr(prod, mbe_pkg::SH_MAG));
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((it_reg < limit_reg) && (mag_reg <= mbe_pkg::FOUR_Q856))
                begin
                    dr_next    = mbe_pkg::sat_add(rsq_reg, ~isq_reg + 64'd1);
                    state_next = S_CROSS;
                    issue_next = 1'b1;
                end
                else
                begin
                    done_next       = 1'b1;
                    iter_count_next = it_reg[mbe_pkg::ITR_W-1:0];
                    in_set_next     = (it_reg == limit_reg);
                    mag_sq_next     = mag_reg;
                    state_next      = S_IDLE;
                end
            end
            S_CROSS:
            begin
                if (mstat.done)
                begin
                    cross_next = mbe_pkg::to_signed_sat(
                        mbe_pkg::usat_shr(prod, mbe_pkg::SH_CROSS),
                        zr_reg[WW-1] ^ zi_reg[WW-1]);
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                zr_next    = mbe_pkg::sat_add(dr_reg, cr_reg);
                zi_next    = mbe_pkg::sat_add(cross_reg, ci_reg);
                it_next    = it_reg + CNT_W'(1);
                state_next = S_SQR;
                issue_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= 1'b0;
            done_reg  <= 1'b0;
            it_reg    <= '0;
            limit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            done_reg  <= done_next;
            it_reg    <= it_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        cr_reg         <= cr_next;
        ci_reg         <= ci_next;
        zr_reg         <= zr_next;
        zi_reg         <= zi_next;
        rsq_reg        <= rsq_next;
        isq_reg        <= isq_next;
        magr_reg       <= magr_next;
        mag_reg        <= mag_next;
        dr_reg         <= dr_next;
        cross_reg      <= cross_next;
        iter_count_reg <= iter_count_next;
        in_set_reg     <= in_set_next;
        mag_sq_reg     <= mag_sq_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign iter_count = iter_count_reg;
    assign in_set     = in_set_reg;
    assign mag_sq     = mag_sq_reg;

    a_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> !mstat.busy)
        else $error("multiplier issued while still running");

    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mstat.done |-> (state_reg == S_MX || state_reg == S_MY || state_reg == S_SQR ||
                        state_reg == S_SQI || state_reg == S_CROSS))
        else $error("product finished outside a multiply state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (it_reg <= limit_reg))
        else $error("iteration count ran past the limit");

    a_escape_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_set) |-> (mag_sq > mbe_pkg::FOUR_Q856))
        else $error("escaped word without magnitude above four");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted pixel did not start the sequencer");

endmodule

`default_nettype wire

@@ src/mandelbrot_escape_time.sv @@
// Escape-time engine for one pixel: a pixel is taken when start is high and busy is low, and
// its result word appears on iter_count, in_set and mag_sq for exactly one cycle with done
// high; the receiver cannot stall it, so it must take the word in that cycle. Every 64x64
// product goes through one shared 32x32 multiplier in four passes. Mapping the pixel takes
// two products, the magnitude check of the starting z two more, and each escape iteration
// three more plus the bookkeeping states S_CHECK and S_UPD. Registers are written over the
// apb port at byte addresses 0, 8, 16, 24 and 32 and should only be changed while idle.
`default_nettype none

module mandelbrot_escape_time #(
    parameter int ITER_LIMIT = mbe_pkg::ITER_LIMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbe_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mbe_pkg::WORD_W-1:0]    pwdata,
    output logic      [mbe_pkg::WORD_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          start,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_x,
    input  wire logic [mbe_pkg::PIX_W-1:0]     pixel_y,
    output logic                               busy,
    output logic                               done,
    output logic      [mbe_pkg::ITR_W-1:0]     iter_count,
    output logic                               in_set,
    output logic      [mbe_pkg::WORD_W-1:0]    mag_sq
);

    mbe_pkg::cfg_t cfg;

    mbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbe_core #(
        .ITER_LIMIT (ITER_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .start      (start),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .busy       (busy),
        .done       (done),
        .iter_count (iter_count),
        .in_set     (in_set),
        .mag_sq     (mag_sq)
    );

endmodule

`default_nettype wire

@@ tb/mandelbrot_escape_time_tb.sv @@
// self-checking testbench for the mandelbrot escape-time engine
module mandelbrot_escape_time_tb;

    localparam int     PIXELS_TARGET = 1050;
    localparam int     TAIL_NO_IDLE  = 150;
    localparam int     LIMIT_CLAMP   = 256;
    localparam int     DRAIN_WAIT    = 8000;
    // every pixel at the full iteration count, plus gaps and bus traffic, times three
    localparam longint CYCLE_LIMIT   = 20_000_000;

    typedef struct packed {
        logic [mbe_pkg::ITR_W-1:0]  iters;
        logic                       in_set;
        logic [mbe_pkg::WORD_W-1:0] mag;
    } escape_t;

    typedef enum logic { ROW_WRITE, ROW_PIXEL } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [2:0]                 reg_idx;
        logic [mbe_pkg::WORD_W-1:0] value;
        logic [mbe_pkg::PIX_W-1:0]  px;
        logic [mbe_pkg::PIX_W-1:0]  py;
        bit                         known;
        escape_t                    want;
    } row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mbe_pkg::ADDR_W-1:0] paddr;
    logic [mbe_pkg::WORD_W-1:0] pwdata;
    logic [mbe_pkg::WORD_W-1:0] prdata;
    logic                       pready;
    logic                       start;
    logic [mbe_pkg::PIX_W-1:0]  pixel_x;
    logic [mbe_pkg::PIX_W-1:0]  pixel_y;
    logic                       busy;
    logic                       done;
    logic [mbe_pkg::ITR_W-1:0]  iter_count;
    logic                       in_set;
    logic [mbe_pkg::WORD_W-1:0] mag_sq;

    mbe_pkg::cfg_t shadow;
    escape_t       expected_escapes[$];
    row_t          rows[$];
    int            n_errors;
    int            n_pixels;
    int            n_in_set;
    int            n_writes;
    int            n_settings;
    longint        n_cycles;

    mandelbrot_escape_time u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- fixed-point escape-time predictor ----------------

    function automatic logic [mbe_pkg::WORD_W-1:0] mag_of(
        input logic [mbe_pkg::WORD_W-1:0] a);
        return a[mbe_pkg::WORD_W-1] ? 64'd0 - a : a;
    endfunction

    // unsigned product shifted right, clamped to 64 bits
    function automatic logic [mbe_pkg::WORD_W-1:0] umul_shr(
        input logic [mbe_pkg::WORD_W-1:0] a,
        input logic [mbe_pkg::WORD_W-1:0] b,
        input int sh);
        logic [mbe_pkg::PROD_W-1:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (|p[mbe_pkg::PROD_W-1:mbe_pkg::WORD_W]) ? '1 : p[mbe_pkg::WORD_W-1:0];
    endfunction

    // signed product, truncated toward zero, clamped to the signed range
    function automatic logic [mbe_pkg::WORD_W-1:0] smul_shr(
        input logic [mbe_pkg::WORD_W-1:0] a,
        input logic [mbe_pkg::WORD_W-1:0] b,
        input int sh);
        logic [mbe_pkg::WORD_W-1:0] m;
        m = umul_shr(mag_of(a), mag_of(b), sh);
        if (a[mbe_pkg::WORD_W-1] != b[mbe_pkg::WORD_W-1])
            return m[mbe_pkg::WORD_W-1] ? mbe_pkg::SMIN : 64'd0 - m;
        return m[mbe_pkg::WORD_W-1] ? mbe_pkg::SMAX : m;
    endfunction

    function automatic logic [mbe_pkg::WORD_W-1:0] add_sat(
        input logic [mbe_pkg::WORD_W-1:0] a,
        input logic [mbe_pkg::WORD_W-1:0] b);
        logic [mbe_pkg::WORD_W:0] s;
        s = {a[mbe_pkg::WORD_W-1], a} + {b[mbe_pkg::WORD_W-1], b};
        if (s[mbe_pkg::WORD_W] != s[mbe_pkg::WORD_W-1])
            return s[mbe_pkg::WORD_W] ? mbe_pkg::SMIN : mbe_pkg::SMAX;
        return s[mbe_pkg::WORD_W-1:0];
    endfunction

    function automatic escape_t escape_time(input mbe_pkg::cfg_t c,
                                            input logic [mbe_pkg::PIX_W-1:0] px,
                                            input logic [mbe_pkg::PIX_W-1:0] py);
        logic [mbe_pkg::WORD_W-1:0] cr, ci, zr, zi, rsq, isq, zrzi, r2, i2, mag;
        int                         limit, it;
        escape_t                    res;
        cr = smul_shr({36'd0, px, 16'd0}
                      + {{16{c.x_offset[mbe_pkg::OFS_W-1]}}, c.x_offset},
                      {16'd0, c.x_scale}, 6);
        ci = smul_shr({36'd0, py, 16'd0}
                      + {{16{c.y_offset[mbe_pkg::OFS_W-1]}}, c.y_offset},
                      {16'd0, c.y_scale}, 6);
        limit = (c.max_iters > LIMIT_CLAMP) ? LIMIT_CLAMP : int'(c.max_iters);
        zr  = '0;
        zi  = '0;
        it  = 0;
        mag = '0;
        while (it < limit && mag <= mbe_pkg::FOUR_Q856)
        begin
            rsq  = smul_shr(zr, zr, 58);
            isq  = smul_shr(zi, zi, 58);
            zrzi = smul_shr(zr, zi, 57);
            zr   = add_sat(add_sat(rsq, 64'd0 - isq), cr);
            zi   = add_sat(zrzi, ci);
            it++;
            r2  = umul_shr(mag_of(zr), mag_of(zr), 60);
            i2  = umul_shr(mag_of(zi), mag_of(zi), 60);
            mag = (r2 > ~i2) ? '1 : r2 + i2;
        end
        res.iters  = it[mbe_pkg::ITR_W-1:0];
        res.in_set = (it == limit);
        res.mag    = mag;
        return res;
    endfunction

    // ---------------- directed table ----------------

    function automatic void tbl_write(input logic [2:0] idx,
                                      input logic [mbe_pkg::WORD_W-1:0] val);
        row_t r;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.value   = val;
        r.px      = '0;
        r.py      = '0;
        r.known   = 1'b0;
        r.want    = '0;
        rows.push_back(r);
    endfunction

    function automatic void tbl_pixel(input logic [mbe_pkg::PIX_W-1:0] x,
                                      input logic [mbe_pkg::PIX_W-1:0] y,
                                      input bit known, input escape_t want);
        row_t r;
        r.kind    = ROW_PIXEL;
        r.reg_idx = mbe_pkg::REG_X_OFFSET;
        r.value   = '0;
        r.px      = x;
        r.py      = y;
        r.known   = known;
        r.want    = want;
        rows.push_back(r);
    endfunction

    // ---------------- drivers ----------------

    // hold off new pixels until every word has come back and the engine is idle, or DRAIN_WAIT runs out
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk) start <= 1'b0;
        while ((expected_escapes.size() != 0 || busy) && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [mbe_pkg::WORD_W-1:0] val);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            mbe_pkg::REG_X_OFFSET:  shadow.x_offset  = val[mbe_pkg::OFS_W-1:0];
            mbe_pkg::REG_Y_OFFSET:  shadow.y_offset  = val[mbe_pkg::OFS_W-1:0];
            mbe_pkg::REG_X_SCALE:   shadow.x_scale   = val[mbe_pkg::SCL_W-1:0];
            mbe_pkg::REG_Y_SCALE:   shadow.y_scale   = val[mbe_pkg::SCL_W-1:0];
            mbe_pkg::REG_MAX_ITERS: shadow.max_iters = val[mbe_pkg::ITR_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // start stays high after acceptance so back-to-back pixels need no extra edge
    task automatic send_pixel(input logic [mbe_pkg::PIX_W-1:0] x,
                              input logic [mbe_pkg::PIX_W-1:0] y,
                              input bit known, input escape_t typed);
        @(negedge clk);
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do @(posedge clk); while (busy);
        expected_escapes.push_back(known ? typed : escape_time(shadow, x, y));
        n_pixels++;
    endtask

    task automatic sender_gap(input bit after_busy);
        int n;
        n = $urandom_range(1, 4);
        @(negedge clk) start <= 1'b0;
        // optionally line the gap up with the end of the current pixel
        if (after_busy)
            while (busy) @(posedge clk);
        repeat (n) @(posedge clk);
    endtask

    task automatic random_setting(output bit heavy);
        logic [63:0]               r;
        logic [mbe_pkg::OFS_W-1:0] ox, oy;
        logic [mbe_pkg::SCL_W-1:0] sx, sy;
        logic [mbe_pkg::ITR_W-1:0] lim;
        int                        mode;
        mode = $urandom_range(0, 9);
        if (mode <= 6)
        begin
            // window around the set: center near pixel 2048, a few units wide
            ox = 48'd0 - {16'd0, 16'($urandom_range(1024, 3072)), 16'($urandom_range(0, 65535))};
            oy = 48'd0 - {16'd0, 16'($urandom_range(1024, 3072)), 16'($urandom_range(0, 65535))};
            r  = {$urandom, $urandom};
            sx = r[mbe_pkg::SCL_W-1:0] >> $urandom_range(9, 13);
            r  = {$urandom, $urandom};
            sy = r[mbe_pkg::SCL_W-1:0] >> $urandom_range(9, 13);
        end
        else if (mode <= 8)
        begin
            r  = {$urandom, $urandom};
            ox = r[mbe_pkg::OFS_W-1:0];
            r  = {$urandom, $urandom};
            oy = r[mbe_pkg::OFS_W-1:0];
            r  = {$urandom, $urandom};
            sx = r[mbe_pkg::SCL_W-1:0];
            r  = {$urandom, $urandom};
            sy = r[mbe_pkg::SCL_W-1:0];
        end
        else
        begin
            ox = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            oy = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            sx = $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
            sy = $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
        end
        case ($urandom_range(0, 15))
            0:       lim = 9'd0;
            1:       lim = 9'd1;
            2:       lim = 9'd256;
            3:       lim = 9'($urandom_range(257, 511));
            4:       lim = 9'($urandom_range(0, 511));
            default: lim = 9'($urandom_range(2, 40));
        endcase
        reg_write(mbe_pkg::REG_X_OFFSET, {16'd0, ox});
        reg_write(mbe_pkg::REG_Y_OFFSET, {16'd0, oy});
        reg_write(mbe_pkg::REG_X_SCALE, {16'd0, sx});
        reg_write(mbe_pkg::REG_Y_SCALE, {16'd0, sy});
        reg_write(mbe_pkg::REG_MAX_ITERS, {55'd0, lim});
        heavy = (lim > 64);
    endtask

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        escape_t want;
        if (rst_n && done)
        begin
            if (expected_escapes.size() == 0)
            begin
                $display("%0t unexpected word: iter_count %0d in_set %0b mag_sq %h",
                         $time, iter_count, in_set, mag_sq);
                n_errors++;
            end
            else
            begin
                want = expected_escapes.pop_front();
                if (iter_count !== want.iters)
                begin
                    $display("%0t iter_count mismatch: expected %0d actual %0d",
                             $time, want.iters, iter_count);
                    n_errors++;
                end
                if (in_set !== want.in_set)
                begin
                    $display("%0t in_set mismatch: expected %0b actual %0b",
                             $time, want.in_set, in_set);
                    n_errors++;
                end
                if (mag_sq !== want.mag)
                begin
                    $display("%0t mag_sq mismatch: expected %h actual %h",
                             $time, want.mag, mag_sq);
                    n_errors++;
                end
                if (in_set === 1'b1)
                    n_in_set++;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("%0t run did not finish within %0d cycles", $time, n_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        int i, count, n_random;
        bit heavy, idling;
        n_errors   = 0;
        n_pixels   = 0;
        n_in_set   = 0;
        n_writes   = 0;
        n_settings = 1;
        n_cycles   = 0;
        n_random   = 0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        pixel_x    = '0;
        pixel_y    = '0;
        shadow     = '{x_offset: '0, y_offset: '0, x_scale: mbe_pkg::SCALE_RST,
                       y_scale: mbe_pkg::SCALE_RST, max_iters: mbe_pkg::ITERS_RST};

        // reset view: origin never escapes, far corners escape at once
        tbl_pixel(12'd0, 12'd0, 1'b1, escape_t'{9'd256, 1'b1, 64'd0});
        tbl_pixel(12'd4095, 12'd4095, 1'b0, '0);
        tbl_pixel(12'd4095, 12'd0, 1'b0, '0);
        tbl_pixel(12'd0, 12'd4095, 1'b0, '0);
        // zero limit runs no iteration
        tbl_write(mbe_pkg::REG_MAX_ITERS, 64'd0);
        tbl_pixel(12'd123, 12'd456, 1'b1, escape_t'{9'd0, 1'b1, 64'd0});
        tbl_pixel(12'd4095, 12'd4095, 1'b1, escape_t'{9'd0, 1'b1, 64'd0});
        tbl_write(mbe_pkg::REG_MAX_ITERS, 64'd1);
        tbl_pixel(12'd0, 12'd0, 1'b1, escape_t'{9'd1, 1'b1, 64'd0});
        tbl_pixel(12'd4095, 12'd4095, 1'b0, '0);
        // pan by -512 pixels: c = -2 sits exactly on |z|^2 = 4 without escaping
        tbl_write(mbe_pkg::REG_MAX_ITERS, 64'd16);
        tbl_write(mbe_pkg::REG_X_OFFSET, 64'h0000_FFFF_FE00_0000);
        tbl_pixel(12'd0, 12'd0, 1'b1, escape_t'{9'd16, 1'b1, mbe_pkg::FOUR_Q856});
        tbl_pixel(12'd0, 12'd1, 1'b0, '0);
        tbl_pixel(12'd512, 12'd0, 1'b1, escape_t'{9'd16, 1'b1, 64'd0});
        tbl_pixel(12'd576, 12'd0, 1'b0, '0);
        // saturating mapping at both ends of the offset and scale ranges
        tbl_write(mbe_pkg::REG_X_OFFSET, 64'h0000_7FFF_FFFF_FFFF);
        tbl_write(mbe_pkg::REG_X_SCALE, 64'h0000_FFFF_FFFF_FFFF);
        tbl_pixel(12'd4095, 12'd0, 1'b0, '0);
        tbl_write(mbe_pkg::REG_X_OFFSET, 64'h0000_8000_0000_0000);
        tbl_pixel(12'd0, 12'd0, 1'b0, '0);
        tbl_write(mbe_pkg::REG_Y_OFFSET, 64'h0000_8000_0000_0000);
        tbl_write(mbe_pkg::REG_Y_SCALE, 64'h0000_FFFF_FFFF_FFFF);
        tbl_pixel(12'd4095, 12'd4095, 1'b0, '0);
        // zero scale collapses every pixel onto the origin
        tbl_write(mbe_pkg::REG_X_SCALE, 64'd0);
        tbl_write(mbe_pkg::REG_Y_SCALE, 64'd0);
        tbl_pixel(12'd4095, 12'd4095, 1'b1, escape_t'{9'd16, 1'b1, 64'd0});
        // limits above 256 clamp
        tbl_write(mbe_pkg::REG_MAX_ITERS, 64'd511);
        tbl_pixel(12'd1, 12'd2, 1'b1, escape_t'{9'd256, 1'b1, 64'd0});
        tbl_write(mbe_pkg::REG_MAX_ITERS, 64'd257);
        tbl_pixel(12'd3000, 12'd17, 1'b1, escape_t'{9'd256, 1'b1, 64'd0});

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (rows[k])
        begin
            if (rows[k].kind == ROW_WRITE)
                reg_write(rows[k].reg_idx, rows[k].value);
            else
                send_pixel(rows[k].px, rows[k].py, rows[k].known, rows[k].want);
        end

        while (n_random < PIXELS_TARGET)
        begin
            random_setting(heavy);
            n_settings++;
            count  = heavy ? 8 : $urandom_range(30, 70);
            idling = $urandom_range(0, 3) != 0;
            for (i = 0; i < count && n_random < PIXELS_TARGET; i++)
            begin
                if (idling && n_random < PIXELS_TARGET - TAIL_NO_IDLE
                    && $urandom_range(0, 2) == 0)
                    sender_gap($urandom_range(0, 1));
                // once mid-setting, let the pipe empty completely
                if (n_settings == 3 && i == count / 2)
                    drain();
                send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           1'b0, '0);
                n_random++;
            end
        end

        drain();
        repeat (64) @(posedge clk);
        if (expected_escapes.size() != 0)
        begin
            $display("%0t %0d words never arrived", $time, expected_escapes.size());
            n_errors += expected_escapes.size();
        end

        $display("%0d pixels over %0d register settings (%0d register writes)",
                 n_pixels, n_settings, n_writes);
        $display("%0d words came back marked inside the set, %0d errors",
                 n_in_set, n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
